// ===== design/wgle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgle_pkg
// Shared codes, widths and controller/datapath interface types of the
// weighted graph Laplacian engine.
// ----------------------------------------------------------------------------
package wgle_pkg;

   // fixed field widths of the transfer payloads
   localparam int ACTION_W   = 2;
   localparam int NODE_IN_W  = 4;
   localparam int WEIGHT_IN_W = 17;
   localparam int STATUS_W   = 2;
   localparam int VALUE_W    = 20;
   localparam int POS_W      = 3;
   localparam int COUNT_W    = 4;

   // value limits of the signed result field
   localparam logic [VALUE_W-2:0] VALUE_MAX      = 19'h7FFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN_BITS = 20'h80000;
   localparam logic [VALUE_W-1:0] NEG_LIMIT      = 20'h80000;

   // node count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD       = 2'd0,
      ACT_QUERY     = 2'd1,
      ACT_LAPLACIAN = 2'd2,
      ACT_UNUSED    = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_SELF     = 2'd2,
      ST_NEGATIVE = 2'd3
   } status_type;

   // which result the output register is loaded with
   typedef enum logic [1:0] {
      OUT_ADD   = 2'd0,
      OUT_QUERY = 2'd1,
      OUT_ENTRY = 2'd2,
      OUT_EMPTY = 2'd3
   } out_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load;
      logic        wr_ab;
      logic        wr_ba;
      logic        rd;
      logic        acc;
      logic        row_end;
      logic        col_inc;
      logic        row_inc;
      logic        out_load;
      out_sel_type out_sel;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      action_type action;
      logic       add_ok;
      logic       n_zero;
      logic       n_le1;
      logic       col_last;
      logic       row_last;
   } dp_stat_type;

endpackage

// ===== design/wgle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgle_ctrl
// Sequencer of the engine: takes one transfer at a time, steps the datapath
// through store writes, row sum walks and entry emission, and holds each
// result until it is transferred.
// ----------------------------------------------------------------------------
module wgle_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wgle_pkg::dp_cmd_type cmd,
   input  wgle_pkg::dp_stat_type stat
);
   import wgle_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_WR_AB     = 10'b00_0000_0010,
      S_WR_BA     = 10'b00_0000_0100,
      S_FIN       = 10'b00_0000_1000,
      S_RD        = 10'b00_0001_0000,
      S_ACC       = 10'b00_0010_0000,
      S_ROW_END   = 10'b00_0100_0000,
      S_EMIT_RD   = 10'b00_1000_0000,
      S_EMIT_LOAD = 10'b01_0000_0000,
      S_RESP      = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (action_type'(req_action))
                  ACT_ADD:       state_in = S_WR_AB;
                  ACT_QUERY:     state_in = stat.n_le1 ? S_FIN : S_RD;
                  ACT_LAPLACIAN: state_in = stat.n_zero ? S_IDLE : S_RD;
                  default:       state_in = S_FIN;
               endcase
            end
         end
         S_WR_AB: begin
            if (stat.add_ok) begin
               cmd.wr_ab = 1'b1;
               state_in  = S_WR_BA;
            end else begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ADD;
               state_in     = S_RESP;
            end
         end
         S_WR_BA: begin
            cmd.wr_ba    = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_ADD;
            state_in     = S_RESP;
         end
         S_FIN: begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = (stat.action == ACT_QUERY) ? OUT_QUERY : OUT_EMPTY;
            state_in     = S_RESP;
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (stat.col_last) begin
               state_in = S_ROW_END;
            end else begin
               cmd.col_inc = 1'b1;
               state_in    = S_RD;
            end
         end
         S_ROW_END: begin
            cmd.row_end = 1'b1;
            if (stat.action == ACT_LAPLACIAN) begin
               state_in = S_EMIT_RD;
            end else if (stat.row_last) begin
               state_in = S_FIN;
            end else begin
               cmd.row_inc = 1'b1;
               state_in    = S_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_EMIT_LOAD;
         end
         S_EMIT_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_ENTRY;
            state_in     = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (stat.action == ACT_LAPLACIAN && !(stat.row_last && stat.col_last)) begin
                  if (stat.col_last) begin
                     cmd.row_inc = 1'b1;
                     state_in    = S_RD;
                  end else begin
                     cmd.col_inc = 1'b1;
                     state_in    = S_EMIT_RD;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/wgle_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgle_dpath
// Datapath of the engine: node count register, adjacency store with
// per-entry valid bits, row and column counters, row sum accumulator,
// minimum tracker and the result register.
// ----------------------------------------------------------------------------
module wgle_dpath #(
   parameter int MAX_NODES   = 8,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  wgle_pkg::dp_cmd_type                      cmd,
   output wgle_pkg::dp_stat_type                     stat,
   input  logic [wgle_pkg::ACTION_W-1:0]             req_action,
   input  logic [wgle_pkg::NODE_IN_W-1:0]            req_node_a,
   input  logic [wgle_pkg::NODE_IN_W-1:0]            req_node_b,
   input  logic signed [wgle_pkg::WEIGHT_IN_W-1:0]   req_edge_weight,
   input  logic                                      csr_wr_en,
   input  logic [wgle_pkg::COUNT_W-1:0]              csr_wr_data,
   output logic [wgle_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [wgle_pkg::VALUE_W-1:0]       rsp_value,
   output logic [wgle_pkg::POS_W-1:0]                rsp_row_index,
   output logic [wgle_pkg::POS_W-1:0]                rsp_col_index,
   output logic                                      rsp_last_item
);
   import wgle_pkg::*;

   localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int DEPTH   = MAX_NODES * MAX_NODES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ACC_W   = WEIGHT_BITS + $clog2(MAX_NODES);
   localparam int CMP_W   = (ACC_W > VALUE_W) ? ACC_W : VALUE_W;
   localparam int WCMP_W  = (WEIGHT_BITS > WEIGHT_IN_W - 1) ? WEIGHT_BITS : WEIGHT_IN_W - 1;

   // latched item
   action_type                 action_ff, action_in;
   logic [NODE_IN_W-1:0]       node_a_ff, node_a_in;
   logic [NODE_IN_W-1:0]       node_b_ff, node_b_in;
   logic [WEIGHT_IN_W-1:0]     weight_ff, weight_in;

   // configuration and walk state
   logic [COUNT_W-1:0]         node_count_ff, node_count_in;
   logic [NODE_W-1:0]          row_ff, row_in;
   logic [NODE_W-1:0]          col_ff, col_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [ACC_W-1:0]           best_ff, best_in;
   logic [VALUE_W-2:0]         deg_ff, deg_in;

   // result register
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic [VALUE_W-1:0]         value_ff, value_in;
   logic [POS_W-1:0]           row_o_ff, row_o_in;
   logic [POS_W-1:0]           col_o_ff, col_o_in;
   logic                       last_ff, last_in;

   // adjacency store
   logic [WEIGHT_BITS-1:0]     store_mem [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [WEIGHT_BITS-1:0]     rd_data_ff;
   logic                       rd_hit_ff;

   logic [CNT_W-1:0]           n_act;
   status_type                 add_status;
   logic                       wr_en;
   logic [ADDR_W-1:0]          waddr;
   logic [ADDR_W-1:0]          raddr;
   logic [WEIGHT_BITS-1:0]     wdata;
   logic [WCMP_W-1:0]          w_mag;
   logic [WCMP_W-1:0]          w_top;
   logic [WEIGHT_BITS-1:0]     rd_weight;
   logic [VALUE_W-1:0]         neg_val;
   logic [VALUE_W-1:0]         entry_val;
   logic                       last_entry;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [NODE_W-1:0] r,
                                                 input logic [NODE_W-1:0] c);
      addr_of = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_NODES) + ADDR_W'(c));
   endfunction

   function automatic logic [VALUE_W-2:0] sat_mag(input logic [ACC_W-1:0] v);
      if (CMP_W'(v) > CMP_W'(VALUE_MAX)) begin
         sat_mag = VALUE_MAX;
      end else begin
         sat_mag = (VALUE_W - 1)'(v);
      end
   endfunction

   // nodes in use, saturated to the store size
   assign n_act = (node_count_ff > COUNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                        : CNT_W'(node_count_ff);

   // add checks in priority order: range, self, sign
   always_comb begin
      if (node_a_ff >= NODE_IN_W'(n_act) || node_b_ff >= NODE_IN_W'(n_act)) begin
         add_status = ST_RANGE;
      end else if (node_a_ff == node_b_ff) begin
         add_status = ST_SELF;
      end else if (weight_ff[WEIGHT_IN_W-1]) begin
         add_status = ST_NEGATIVE;
      end else begin
         add_status = ST_OK;
      end
   end

   // status toward the controller
   assign stat.action   = action_ff;
   assign stat.add_ok   = (add_status == ST_OK);
   assign stat.n_zero   = (n_act == '0);
   assign stat.n_le1    = (n_act <= CNT_W'(1));
   assign stat.col_last = (CNT_W'(col_ff) == n_act - CNT_W'(1));
   assign stat.row_last = (CNT_W'(row_ff) == n_act - CNT_W'(1));

   // weight clipped to the stored width
   assign w_mag = WCMP_W'(weight_ff[WEIGHT_IN_W-2:0]);
   assign w_top = WCMP_W'({WEIGHT_BITS{1'b1}});
   assign wdata = WEIGHT_BITS'((w_mag > w_top) ? w_top : w_mag);

   // store addressing
   assign wr_en = cmd.wr_ab | cmd.wr_ba;
   assign waddr = cmd.wr_ab ? addr_of(node_a_ff[NODE_W-1:0], node_b_ff[NODE_W-1:0])
                            : addr_of(node_b_ff[NODE_W-1:0], node_a_ff[NODE_W-1:0]);
   assign raddr = addr_of(row_ff, col_ff);

   // entries never written read as zero
   assign rd_weight = rd_hit_ff ? rd_data_ff : '0;

   // off-diagonal entry: negated weight, clipped at the most negative value
   assign neg_val   = (CMP_W'(rd_weight) > CMP_W'(NEG_LIMIT))
                    ? VALUE_MIN_BITS : ('0 - VALUE_W'(rd_weight));
   assign entry_val = (row_ff == col_ff) ? {1'b0, deg_ff} : neg_val;
   assign last_entry = stat.row_last & stat.col_last;

   // next values of the item, walk and result registers
   always_comb begin
      action_in     = action_ff;
      node_a_in     = node_a_ff;
      node_b_in     = node_b_ff;
      weight_in     = weight_ff;
      node_count_in = node_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      deg_in        = deg_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      row_o_in      = row_o_ff;
      col_o_in      = col_o_ff;
      last_in       = last_ff;

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
      end

      if (cmd.load) begin
         action_in = action_type'(req_action);
         node_a_in = req_node_a;
         node_b_in = req_node_b;
         weight_in = req_edge_weight;
         row_in    = '0;
         col_in    = '0;
         acc_in    = '0;
         best_in   = '0;
      end

      // row sum, diagonal skipped
      if (cmd.acc && row_ff != col_ff) begin
         acc_in = acc_ff + ACC_W'(rd_weight);
      end

      // end of a row: degree for the Laplacian, running minimum for a query
      if (cmd.row_end) begin
         if (action_ff == ACT_LAPLACIAN) begin
            deg_in = sat_mag(acc_ff);
            col_in = '0;
         end else if (row_ff == '0 || acc_ff < best_ff) begin
            best_in = acc_ff;
         end
      end

      if (cmd.col_inc) begin
         col_in = col_ff + NODE_W'(1);
      end

      if (cmd.row_inc) begin
         row_in = row_ff + NODE_W'(1);
         col_in = '0;
         acc_in = '0;
      end

      // result register load
      if (cmd.out_load) begin
         case (cmd.out_sel)
            OUT_ADD: begin
               status_in = add_status;
               value_in  = '0;
               row_o_in  = '0;
               col_o_in  = '0;
               last_in   = 1'b1;
            end
            OUT_QUERY: begin
               status_in = ST_OK;
               value_in  = {1'b0, sat_mag(best_ff)};
               row_o_in  = '0;
               col_o_in  = '0;
               last_in   = 1'b1;
            end
            OUT_ENTRY: begin
               status_in = ST_OK;
               value_in  = entry_val;
               row_o_in  = POS_W'(row_ff);
               col_o_in  = POS_W'(col_ff);
               last_in   = last_entry;
            end
            default: begin
               status_in = ST_OK;
               value_in  = '0;
               row_o_in  = '0;
               col_o_in  = '0;
               last_in   = 1'b1;
            end
         endcase
      end
   end

   // registers that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_RESET;
         valid_ff      <= '0;
      end else begin
         node_count_ff <= node_count_in;
         if (wr_en) begin
            valid_ff[waddr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      node_a_ff <= node_a_in;
      node_b_ff <= node_b_in;
      weight_ff <= weight_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      acc_ff    <= acc_in;
      best_ff   <= best_in;
      deg_ff    <= deg_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      row_o_ff  <= row_o_in;
      col_o_ff  <= col_o_in;
      last_ff   <= last_in;
   end

   // adjacency store, one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[waddr] <= wdata;
      end
      if (cmd.rd) begin
         rd_data_ff <= store_mem[raddr];
         rd_hit_ff  <= valid_ff[raddr];
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_value     = value_ff;
   assign rsp_row_index = row_o_ff;
   assign rsp_col_index = col_o_ff;
   assign rsp_last_item = last_ff;

endmodule

// ===== design/weighted_graph_laplacian_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_graph_laplacian_engine_top
// Keeps a symmetric weighted adjacency store of MAX_NODES x MAX_NODES
// entries, cleared at reset through per-entry valid bits (no clearing pass),
// and serves one request at a time. An add makes two store writes through
// the single write port, then loads the result register (a rejected add
// skips the writes). A minimum degree query walks the store with registered
// reads, one row at a time (none when n is one or less). A Laplacian request
// emits n*n entries for n nodes in use: each row first sums its degree, then
// each entry of the row is read, loaded and shown, and any output stall holds
// the walk. A Laplacian request with no node in use completes without a
// result. The node count register must be written only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module weighted_graph_laplacian_engine_top #(
   parameter int MAX_NODES   = 8,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [wgle_pkg::ACTION_W-1:0]             req_action,
   input  logic [wgle_pkg::NODE_IN_W-1:0]            req_node_a,
   input  logic [wgle_pkg::NODE_IN_W-1:0]            req_node_b,
   input  logic signed [wgle_pkg::WEIGHT_IN_W-1:0]   req_edge_weight,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [wgle_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [wgle_pkg::VALUE_W-1:0]       rsp_value,
   output logic [wgle_pkg::POS_W-1:0]                rsp_row_index,
   output logic [wgle_pkg::POS_W-1:0]                rsp_col_index,
   output logic                                      rsp_last_item,
   input  logic                                      csr_wr_en,
   input  logic [wgle_pkg::COUNT_W-1:0]              csr_wr_data
);
   import wgle_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   wgle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   // store, counters and result register
   wgle_dpath #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_edge_weight (req_edge_weight),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_status      (rsp_status),
      .rsp_value       (rsp_value),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_last_item   (rsp_last_item)
   );

`ifndef NO_ASSERTIONS
   // no new request is taken while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // every result transfer is followed by work or idle before another result is shown
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result shown twice in a row");

   // a rejected add carries a zero value and ends its request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value == '0 && rsp_last_item))
      else $error("error result with value or not last");

   // an accepted request other than a Laplacian stalls the input on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action != ACT_LAPLACIAN) |=> req_stall)
      else $error("input not stalled after a request");
`endif

endmodule
